/* rtl/tgtw_pkg.sv */
// Shared types, constants and helpers for the text glyph tile-map writer.
package tgtw_pkg;

  // Screen and font limits
  localparam int SCREEN_COLS   = 48;
  localparam int LAST_ROW      = 27;
  localparam int TAB_STEP      = 4;
  localparam int MAX_GLYPH_DIM = 4;

  localparam int DIM_W    = $clog2(MAX_GLYPH_DIM + 1);
  localparam int CH_W     = 8;
  localparam int CUR_W    = 8;
  localparam int GPR_W    = 7;
  localparam int LINE_W   = GPR_W + DIM_W;
  localparam int EW_W     = CH_W + DIM_W;
  localparam int IDX_W    = 12;
  localparam int WORD_W   = 16;
  localparam int DIVCNT_W = $clog2(CH_W);
  localparam int PAL_SHIFT  = 14;
  localparam int MAP_STRIDE = 64;

  // Control codes in the character stream
  localparam logic [CH_W-1:0] CODE_CR  = 8'd13;
  localparam logic [CH_W-1:0] CODE_TAB = 8'd9;
  localparam logic [CH_W-1:0] CODE_NL  = 8'd10;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam logic [2:0] REG_TILE_OFFSET    = 3'd0;
  localparam logic [2:0] REG_FONT_WIDTH     = 3'd1;
  localparam logic [2:0] REG_FONT_HEIGHT    = 3'd2;
  localparam logic [2:0] REG_GLYPHS_PER_ROW = 3'd3;
  localparam logic [2:0] REG_FIRST_CODE     = 3'd4;
  localparam logic [2:0] REG_PALETTE        = 3'd5;
  localparam logic [2:0] REG_VERTICAL       = 3'd6;
  localparam logic [2:0] REG_RIGHT_TO_LEFT  = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic             first;
    logic [CUR_W-1:0] start_x;
    logic [CUR_W-1:0] start_y;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  map_index;
    logic [WORD_W-1:0] map_word;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [10:0]      tile_offset;
    logic [2:0]       font_width;
    logic [2:0]       font_height;
    logic [GPR_W-1:0] glyphs_per_row;
    logic [CH_W-1:0]  first_code;
    logic [1:0]       palette;
    logic             vertical;
    logic             right_to_left;
  } cfg_t;

  // Operation the controller asks of the datapath in a cycle
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_STOP,
    DP_TAB,
    DP_NEWLINE,
    DP_SETUP_SINGLE,
    DP_SETUP_LARGE,
    DP_DIV_STEP,
    DP_MUL1,
    DP_MUL2,
    DP_EMIT,
    DP_ADVANCE
  } dp_op_t;

  // Classification of the current character
  typedef enum logic [2:0] {
    KIND_CR,
    KIND_TAB,
    KIND_NL,
    KIND_SINGLE,
    KIND_LARGE
  } char_kind_t;

  typedef struct packed {
    logic       stop;
    char_kind_t kind;
    logic       div_done;
    logic       empty;
    logic       emit_last;
  } dp_status_t;

  // Glyph dimension limited to the largest supported size
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [2:0] d);
    logic [DIM_W-1:0] res;
    if (32'(d) > MAX_GLYPH_DIM) begin
      res = DIM_W'(MAX_GLYPH_DIM);
    end else begin
      res = DIM_W'(d);
    end
    return res;
  endfunction

endpackage

/* rtl/tgtw_cfg_regs.sv */
// APB-style configuration register file.
module tgtw_cfg_regs
  import tgtw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_offset    <= '0;
      cfg_r.font_width     <= 3'd1;
      cfg_r.font_height    <= 3'd1;
      cfg_r.glyphs_per_row <= 7'd32;
      cfg_r.first_code     <= 8'd32;
      cfg_r.palette        <= '0;
      cfg_r.vertical       <= 1'b0;
      cfg_r.right_to_left  <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TILE_OFFSET:    cfg_r.tile_offset    <= pwdata[10:0];
        REG_FONT_WIDTH:     cfg_r.font_width     <= pwdata[2:0];
        REG_FONT_HEIGHT:    cfg_r.font_height    <= pwdata[2:0];
        REG_GLYPHS_PER_ROW: cfg_r.glyphs_per_row <= pwdata[GPR_W-1:0];
        REG_FIRST_CODE:     cfg_r.first_code     <= pwdata[CH_W-1:0];
        REG_PALETTE:        cfg_r.palette        <= pwdata[1:0];
        REG_VERTICAL:       cfg_r.vertical       <= pwdata[0];
        REG_RIGHT_TO_LEFT:  cfg_r.right_to_left  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      REG_TILE_OFFSET:    prdata = CFG_DW'(cfg_r.tile_offset);
      REG_FONT_WIDTH:     prdata = CFG_DW'(cfg_r.font_width);
      REG_FONT_HEIGHT:    prdata = CFG_DW'(cfg_r.font_height);
      REG_GLYPHS_PER_ROW: prdata = CFG_DW'(cfg_r.glyphs_per_row);
      REG_FIRST_CODE:     prdata = CFG_DW'(cfg_r.first_code);
      REG_PALETTE:        prdata = CFG_DW'(cfg_r.palette);
      REG_VERTICAL:       prdata = CFG_DW'(cfg_r.vertical);
      REG_RIGHT_TO_LEFT:  prdata = CFG_DW'(cfg_r.right_to_left);
      default:            prdata = '0;
    endcase
  end

endmodule

/* rtl/tgtw_ctrl.sv */
// Controller state machine: sequences each character through the datapath.
module tgtw_ctrl
  import tgtw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_op_t     op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_MUL1,
    S_MUL2,
    S_EMIT,
    S_ADV
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    op        = DP_IDLE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          op        = DP_LOAD;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_IDLE;
        if (status.stop) begin
          op = DP_STOP;
        end else begin
          unique case (status.kind)
            KIND_CR:  op = DP_IDLE;
            KIND_TAB: op = DP_TAB;
            KIND_NL:  op = DP_NEWLINE;
            KIND_SINGLE: begin
              op        = DP_SETUP_SINGLE;
              state_nxt = S_EMIT;
            end
            KIND_LARGE: begin
              op        = DP_SETUP_LARGE;
              state_nxt = S_DIV;
            end
            default: op = DP_IDLE;
          endcase
        end
      end
      S_DIV: begin
        op = DP_DIV_STEP;
        if (status.div_done) begin
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        op        = DP_MUL1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        op        = DP_MUL2;
        state_nxt = status.empty ? S_ADV : S_EMIT;
      end
      S_EMIT: begin
        op = DP_EMIT;
        if (status.emit_last) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        op        = DP_ADVANCE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

/* rtl/tgtw_datapath.sv */
// Datapath: cursor state, glyph base divider/multiplier and map-word output register.
module tgtw_datapath
  import tgtw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  dp_op_t     op,
  input  in_item_t   in_data,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data
);

  // Control state (reset)
  logic [CUR_W-1:0] cursor_x_r, cursor_y_r, home_r;
  logic             stopped_r;
  logic             out_valid_r;
  logic [DIVCNT_W-1:0] div_cnt_r;

  // Payload state
  logic [CH_W-1:0]   ch_r;
  logic [CH_W-1:0]   entry_r;
  logic [LINE_W-1:0] line_r;
  logic [GPR_W-1:0]  rem_r;
  logic [CH_W-1:0]   quo_r;
  logic [WORD_W-1:0] prod_r;
  logic [EW_W-1:0]   ew_r;
  logic [WORD_W-1:0] tile_r, col_tile_r;
  logic [IDX_W-1:0]  idx_r, col_idx_r;
  logic [DIM_W-1:0]  c_r, r_r, dim_w_r, dim_h_r;
  out_item_t         out_r;

  logic [DIM_W-1:0]  w, h;
  logic [CUR_W-1:0]  w8, h8;
  logic [GPR_W-1:0]  gpr;
  logic [IDX_W-1:0]  pos;
  logic              out_free;
  logic              at_last;
  logic              col_end;
  logic [CH_W-1:0]   rem_sh;
  logic              rem_ge;
  logic [WORD_W-1:0] tab_step_x, tab_step_y;
  logic [WORD_W-1:0] tab_x, tab_y;
  logic [CUR_W-1:0]  adv_x, adv_y;
  logic [WORD_W-1:0] base_large;

  assign w   = clamp_dim(cfg.font_width);
  assign h   = clamp_dim(cfg.font_height);
  assign w8  = CUR_W'(w);
  assign h8  = CUR_W'(h);
  assign gpr = (cfg.glyphs_per_row == '0) ? GPR_W'(1) : cfg.glyphs_per_row;
  assign pos = {cursor_y_r[5:0], 6'b0} + IDX_W'(cursor_x_r);

  assign out_free = !out_valid_r || out_ready;
  assign col_end  = (r_r == dim_h_r - DIM_W'(1));
  assign at_last  = col_end && (c_r == dim_w_r - DIM_W'(1));

  // One restoring division step: entry / glyphs per row
  assign rem_sh = {rem_r, quo_r[CH_W-1]};
  assign rem_ge = (rem_sh >= CH_W'(gpr));

  // Next tab stop along x or y
  assign tab_step_x = WORD_W'((WORD_W'(cursor_x_r) / WORD_W'(TAB_STEP) + WORD_W'(1))
                              * WORD_W'(TAB_STEP));
  assign tab_step_y = WORD_W'((WORD_W'(cursor_y_r) / WORD_W'(TAB_STEP) + WORD_W'(1))
                              * WORD_W'(TAB_STEP));
  assign tab_x = WORD_W'(tab_step_x * WORD_W'(w));
  assign tab_y = WORD_W'(tab_step_y * WORD_W'(h));

  // Glyph base tile: offset + entry*w + quotient*line*(h-1)
  assign base_large = WORD_W'(cfg.tile_offset) + WORD_W'(ew_r)
                    + WORD_W'(prod_r * WORD_W'(h - DIM_W'(1)));

  // Cursor advance after a glyph, with wrap to the next line
  always_comb begin
    adv_x = cursor_x_r;
    adv_y = cursor_y_r;
    if (!cfg.vertical) begin
      adv_x = cfg.right_to_left ? cursor_x_r - w8 : cursor_x_r + w8;
    end else begin
      adv_y = cfg.right_to_left ? cursor_y_r - h8 : cursor_y_r + h8;
    end
    if (adv_x >= CUR_W'(SCREEN_COLS)) begin
      adv_y = cfg.right_to_left ? adv_y - h8 : adv_y + h8;
      adv_x = home_r;
    end
  end

  // Status back to the controller
  always_comb begin
    status.stop = stopped_r || (cursor_x_r >= CUR_W'(SCREEN_COLS))
                || (cursor_y_r > CUR_W'(LAST_ROW));
    if (ch_r == CODE_CR) begin
      status.kind = KIND_CR;
    end else if (ch_r == CODE_TAB) begin
      status.kind = KIND_TAB;
    end else if (ch_r == CODE_NL) begin
      status.kind = KIND_NL;
    end else if ((w > DIM_W'(1)) || (h > DIM_W'(1))) begin
      status.kind = KIND_LARGE;
    end else begin
      status.kind = KIND_SINGLE;
    end
    status.div_done  = (div_cnt_r == DIVCNT_W'(CH_W - 1));
    status.empty     = (dim_w_r == '0) || (dim_h_r == '0);
    status.emit_last = out_free && at_last;
  end

  // Cursor, stop flag, divider count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r  <= '0;
      cursor_y_r  <= '0;
      home_r      <= '0;
      stopped_r   <= 1'b1;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (op)
        DP_LOAD: begin
          if (in_data.first) begin
            cursor_x_r <= in_data.start_x;
            cursor_y_r <= in_data.start_y;
            home_r     <= in_data.start_x;
            stopped_r  <= 1'b0;
          end
        end
        DP_STOP: stopped_r <= 1'b1;
        DP_TAB: begin
          if (!cfg.vertical) begin
            cursor_x_r <= tab_x[CUR_W-1:0];
          end else begin
            cursor_y_r <= tab_y[CUR_W-1:0];
          end
        end
        DP_NEWLINE: begin
          cursor_y_r <= cfg.right_to_left ? cursor_y_r - h8 : cursor_y_r + h8;
          cursor_x_r <= home_r;
        end
        DP_SETUP_LARGE: div_cnt_r <= '0;
        DP_DIV_STEP:    div_cnt_r <= div_cnt_r + DIVCNT_W'(1);
        DP_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
          end
        end
        DP_ADVANCE: begin
          cursor_x_r <= adv_x;
          cursor_y_r <= adv_y;
        end
        default: ;
      endcase
    end
  end

  // Glyph arithmetic and the column-major walk over its tiles
  always_ff @(posedge clk) begin
    case (op)
      DP_LOAD: ch_r <= in_data.ch;
      DP_SETUP_SINGLE: begin
        tile_r     <= WORD_W'(cfg.tile_offset) + WORD_W'(ch_r) - WORD_W'(cfg.first_code);
        col_tile_r <= WORD_W'(cfg.tile_offset) + WORD_W'(ch_r) - WORD_W'(cfg.first_code);
        idx_r      <= pos;
        col_idx_r  <= pos;
        line_r     <= LINE_W'(gpr * w);
        dim_w_r    <= DIM_W'(1);
        dim_h_r    <= DIM_W'(1);
        c_r        <= '0;
        r_r        <= '0;
      end
      DP_SETUP_LARGE: begin
        entry_r <= ch_r - cfg.first_code;
        quo_r   <= ch_r - cfg.first_code;
        rem_r   <= '0;
        line_r  <= LINE_W'(gpr * w);
        dim_w_r <= w;
        dim_h_r <= h;
      end
      DP_DIV_STEP: begin
        rem_r <= rem_ge ? GPR_W'(rem_sh - CH_W'(gpr)) : rem_sh[GPR_W-1:0];
        quo_r <= {quo_r[CH_W-2:0], rem_ge};
      end
      DP_MUL1: begin
        prod_r <= WORD_W'(quo_r * line_r);
        ew_r   <= EW_W'(entry_r * w);
      end
      DP_MUL2: begin
        tile_r     <= base_large;
        col_tile_r <= base_large;
        idx_r      <= pos;
        col_idx_r  <= pos;
        c_r        <= '0;
        r_r        <= '0;
      end
      DP_EMIT: begin
        if (out_free) begin
          out_r.map_index <= idx_r;
          out_r.map_word  <= tile_r | {cfg.palette, {PAL_SHIFT{1'b0}}};
          out_r.last      <= at_last;
          // Step down the column, or on to the top of the next one
          if (col_end) begin
            r_r        <= '0;
            c_r        <= c_r + DIM_W'(1);
            col_tile_r <= col_tile_r + WORD_W'(1);
            tile_r     <= col_tile_r + WORD_W'(1);
            col_idx_r  <= col_idx_r + IDX_W'(1);
            idx_r      <= col_idx_r + IDX_W'(1);
          end else begin
            r_r    <= r_r + DIM_W'(1);
            tile_r <= tile_r + WORD_W'(line_r);
            idx_r  <= idx_r + IDX_W'(MAP_STRIDE);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* rtl/text_glyph_tilemap_writer_core.sv */
// Top level of the text glyph tile-map writer.
//
//  Channel | Direction | Handshake              | Content
//  in_     | request   | in_valid / in_ready    | in_item_t: ch, first, start_x, start_y
//  out_    | response  | out_valid / out_ready  | out_item_t: map_index, map_word, last
//  cfg     | APB write | psel/penable/pwrite    | eight registers at 4*i, pready always 1
//
// A request is taken while the controller is idle. CR, tab, newline and stopped
// characters return straight to idle; a one-tile glyph passes setup, emit, advance;
// a larger glyph runs the 8-step entry / glyphs_per_row divider and the multiplies,
// then one map word per cycle; a stalled out_ready holds the word walk in place.
// Synchronous active-low reset returns registers and cursor to defaults, stopped set.
module text_glyph_tilemap_writer_core
  import tgtw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_op_t     op;
  dp_status_t status;

  tgtw_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tgtw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .op       (op)
  );

  tgtw_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .op        (op),
    .in_data   (in_data),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* dv/tb_text_glyph_tilemap_writer_core.sv */
// Self-checking testbench for the text glyph tile-map writer core.
module tb_text_glyph_tilemap_writer_core;
  import tgtw_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned CFG_EVERY     = 30;     // requests between font changes

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [CFG_AW-1:0] paddr     = '0;
  logic [CFG_DW-1:0] pwdata    = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  text_glyph_tilemap_writer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Font registers as the block should hold them
  logic [10:0] font_base    = 11'd0;
  logic [2:0]  glyph_w      = 3'd1;
  logic [2:0]  glyph_h      = 3'd1;
  logic [6:0]  sheet_cols   = 7'd32;
  logic [7:0]  code_base    = 8'd32;
  logic [1:0]  pal_sel      = 2'd0;
  logic        adv_vertical = 1'b0;
  logic        adv_reverse  = 1'b0;

  // Cursor state
  logic [7:0] cur_x    = 8'd0;
  logic [7:0] cur_y    = 8'd0;
  logic [7:0] home_col = 8'd0;
  logic       halted   = 1'b1;

  out_item_t   map_writes_q[$];
  int unsigned handled_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;

  event hold_start;
  logic hold_on = 1'b0;

  // Return to the home column one glyph row further on
  function automatic void line_feed(input int unsigned h);
    cur_y = adv_reverse ? 8'(cur_y - h) : 8'(cur_y + h);
    cur_x = home_col;
  endfunction

  // Expected map writes for one accepted request, cursor updated
  function automatic void predict_map_writes(input in_item_t req);
    int unsigned w, h, cols, entry, stride, base, pos, c, r;
    out_item_t   wr;
    w = (glyph_w > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : glyph_w;
    h = (glyph_h > MAX_GLYPH_DIM) ? MAX_GLYPH_DIM : glyph_h;
    if (req.first) begin
      cur_x    = req.start_x;
      cur_y    = req.start_y;
      home_col = req.start_x;
      halted   = 1'b0;
    end
    if (halted || cur_x >= SCREEN_COLS || cur_y > LAST_ROW) begin
      halted = 1'b1;
      return;
    end
    handled_count++;
    pos = cur_y * MAP_STRIDE + cur_x;
    case (req.ch)
      CODE_CR: return;
      CODE_TAB: begin
        if (!adv_vertical) begin
          cur_x = 8'((cur_x / TAB_STEP + 1) * TAB_STEP * w);
        end else begin
          cur_y = 8'((cur_y / TAB_STEP + 1) * TAB_STEP * h);
        end
        return;
      end
      CODE_NL: begin
        line_feed(h);
        return;
      end
      default: ;
    endcase
    if (w > 1 || h > 1) begin
      cols   = (sheet_cols == 0) ? 1 : sheet_cols;
      entry  = (req.ch - code_base) & 32'hFF;
      stride = cols * w;
      base   = font_base + entry * w + (entry / cols) * stride * (h - 1);
      // column-major walk over the glyph tiles
      for (c = 0; c < w; c++) begin
        for (r = 0; r < h; r++) begin
          wr.map_index = 12'(pos + c + r * MAP_STRIDE);
          wr.map_word  = 16'(base + c + r * stride) | {pal_sel, 14'd0};
          wr.last      = (c == w - 1) && (r == h - 1);
          map_writes_q.push_back(wr);
        end
      end
    end else begin
      // one-tile glyph: no 8-bit wrap of the code difference
      base         = font_base + req.ch - code_base;
      wr.map_index = 12'(pos);
      wr.map_word  = 16'(base) | {pal_sel, 14'd0};
      wr.last      = 1'b1;
      map_writes_q.push_back(wr);
    end
    if (!adv_vertical) begin
      cur_x = adv_reverse ? 8'(cur_x - w) : 8'(cur_x + w);
    end else begin
      cur_y = adv_reverse ? 8'(cur_y - h) : 8'(cur_y + h);
    end
    if (cur_x >= SCREEN_COLS) begin
      line_feed(h);
    end
  endfunction

  // Offer one request; called and returns at a falling edge, valid left high
  task automatic send_request(input logic [7:0] ch, input logic first,
                              input logic [7:0] sx, input logic [7:0] sy);
    in_item_t req;
    req.ch      = ch;
    req.first   = first;
    req.start_x = sx;
    req.start_y = sy;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_map_writes(req);
    @(negedge clk);
  endtask

  // Stop offering, wait for all map writes, then let the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (map_writes_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup then access phase
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TILE_OFFSET:    font_base    = val[10:0];
      REG_FONT_WIDTH:     glyph_w      = val[2:0];
      REG_FONT_HEIGHT:    glyph_h      = val[2:0];
      REG_GLYPHS_PER_ROW: sheet_cols   = val[6:0];
      REG_FIRST_CODE:     code_base    = val[7:0];
      REG_PALETTE:        pal_sel      = val[1:0];
      REG_VERTICAL:       adv_vertical = val[0];
      REG_RIGHT_TO_LEFT:  adv_reverse  = val[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic randomize_font();
    write_reg(REG_TILE_OFFSET, $urandom_range(0, 2047));
    write_reg(REG_FONT_WIDTH,
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7));
    write_reg(REG_FONT_HEIGHT,
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7));
    write_reg(REG_GLYPHS_PER_ROW,
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 64) : $urandom_range(0, 127));
    write_reg(REG_FIRST_CODE, $urandom_range(0, 255));
    write_reg(REG_PALETTE, $urandom_range(0, 3));
    write_reg(REG_VERTICAL, $urandom_range(0, 1));
    write_reg(REG_RIGHT_TO_LEFT, $urandom_range(0, 1));
  endtask

  // Mostly printable codes, some control codes
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 19))
      0: return CODE_TAB;
      1: return CODE_NL;
      2: return CODE_CR;
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  // Reset font: one-tile glyphs, stop handling, wraps and control codes
  task automatic test_default_font();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    send_request(8'd65, 1'b0, 8'd0, 8'd0);     // no string started yet
    send_request(8'd65, 1'b1, 8'd0, 8'd0);
    send_request(8'd255, 1'b0, 8'd0, 8'd0);
    send_request(8'd1, 1'b0, 8'd0, 8'd0);      // code below first_code
    send_request(CODE_CR, 1'b0, 8'd0, 8'd0);
    send_request(CODE_TAB, 1'b0, 8'd0, 8'd0);
    send_request(CODE_NL, 1'b0, 8'd0, 8'd0);
    send_request(8'd66, 1'b1, 8'd47, 8'd27);   // last cell, wraps past last row
    send_request(8'd67, 1'b0, 8'd0, 8'd0);
    send_request(8'd68, 1'b1, 8'd48, 8'd0);
    send_request(8'd69, 1'b1, 8'hFF, 8'hFF);
    send_request(8'd70, 1'b1, 8'd0, 8'd28);
  endtask

  // Register extremes: 4x4, clamped, empty and zero-size glyphs
  task automatic test_font_extremes();
    wait_idle();
    write_reg(REG_TILE_OFFSET, 32'd2047);
    write_reg(REG_FONT_WIDTH, 32'd4);
    write_reg(REG_FONT_HEIGHT, 32'd4);
    write_reg(REG_GLYPHS_PER_ROW, 32'd64);
    write_reg(REG_FIRST_CODE, 32'd0);
    write_reg(REG_PALETTE, 32'd3);
    write_reg(REG_VERTICAL, 32'd0);
    write_reg(REG_RIGHT_TO_LEFT, 32'd0);
    send_request(8'd255, 1'b1, 8'd40, 8'd20);
    send_request(8'd1, 1'b0, 8'd0, 8'd0);
    send_request(CODE_TAB, 1'b0, 8'd0, 8'd0);
    send_request(8'd97, 1'b0, 8'd0, 8'd0);
    // zero width: nothing written, cursor still moves up
    wait_idle();
    write_reg(REG_FONT_WIDTH, 32'd0);
    write_reg(REG_FONT_HEIGHT, 32'd3);
    write_reg(REG_GLYPHS_PER_ROW, 32'd0);
    write_reg(REG_VERTICAL, 32'd1);
    write_reg(REG_RIGHT_TO_LEFT, 32'd1);
    send_request(8'd120, 1'b1, 8'd5, 8'd5);
    send_request(CODE_NL, 1'b0, 8'd0, 8'd0);
    // oversized dimensions act as the largest glyph
    wait_idle();
    write_reg(REG_FONT_WIDTH, 32'd7);
    write_reg(REG_FONT_HEIGHT, 32'd7);
    write_reg(REG_GLYPHS_PER_ROW, 32'd1);
    write_reg(REG_RIGHT_TO_LEFT, 32'd0);
    write_reg(REG_TILE_OFFSET, 32'd0);
    write_reg(REG_FIRST_CODE, 32'd255);
    send_request(8'd254, 1'b1, 8'd10, 8'd0);
    send_request(CODE_TAB, 1'b0, 8'd0, 8'd0);
    // both dimensions zero fall back to a single write
    wait_idle();
    write_reg(REG_FONT_WIDTH, 32'd0);
    write_reg(REG_FONT_HEIGHT, 32'd0);
    write_reg(REG_VERTICAL, 32'd0);
    send_request(8'd33, 1'b1, 8'd0, 8'd0);
    send_request(CODE_NL, 1'b1, 8'd47, 8'd0);
  endtask

  // Random strings over random fonts, mostly with a valid start
  task automatic test_random_strings(input int unsigned n_items, input int unsigned s_idle,
                                     input int unsigned r_idle);
    int unsigned goal, since_cfg, len, k;
    logic        well_formed;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    goal          = handled_count + n_items;
    since_cfg     = CFG_EVERY;
    while (handled_count < goal) begin
      if (since_cfg >= CFG_EVERY) begin
        wait_idle();
        randomize_font();
        since_cfg = 0;
      end
      len         = $urandom_range(1, 12);
      well_formed = ($urandom_range(0, 9) != 0);
      for (k = 0; k < len; k++) begin
        if (k == 0 && well_formed) begin
          send_request(pick_char(), 1'b1, 8'($urandom_range(0, SCREEN_COLS - 1)),
                       8'($urandom_range(0, LAST_ROW)));
        end else begin
          send_request(pick_char(), ($urandom_range(0, 29) == 0),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
        since_cfg++;
      end
    end
  endtask

  // Receiver holds off while 2x2 glyphs keep coming, input must stall
  task automatic test_input_backpressure();
    int unsigned k;
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_FONT_WIDTH, 32'd2);
    write_reg(REG_FONT_HEIGHT, 32'd2);
    write_reg(REG_VERTICAL, 32'd0);
    write_reg(REG_RIGHT_TO_LEFT, 32'd0);
    -> hold_start;
    send_request(8'd65, 1'b1, 8'd0, 8'd0);
    for (k = 1; k < 24; k++) begin
      send_request(8'(65 + k), 1'b0, 8'd0, 8'd0);
    end
  endtask

  // Long receiver hold-off
  always begin
    @(hold_start);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  // Receiver readiness
  always @(negedge clk) begin
    if (hold_on) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Check each map write against the oldest expected one
  always @(posedge clk) begin : check_map_writes
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (map_writes_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("unexpected map write: idx %0d word %h last %0d",
                   out_data.map_index, out_data.map_word, out_data.last);
        end
        mismatch_count++;
      end else begin
        want = map_writes_q.pop_front();
        if (out_data.map_index !== want.map_index || out_data.map_word !== want.map_word ||
            out_data.last !== want.last) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("map write mismatch: expected idx %0d word %h last %0d, got idx %0d word %h last %0d",
                     want.map_index, want.map_word, want.last,
                     out_data.map_index, out_data.map_word, out_data.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("text_glyph_tilemap_writer_core verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_default_font();
    test_font_extremes();
    test_random_strings(50, 34, 62);
    test_random_strings(50, 62, 34);
    test_random_strings(50, 0, 0);
    test_input_backpressure();
    wait_idle();
    if (mismatch_count == 0 && map_writes_q.size() == 0) begin
      $display("text_glyph_tilemap_writer_core verification clean");
    end else begin
      $display("text_glyph_tilemap_writer_core verification failed");
    end
    $finish;
  end

endmodule
